>>> sv/decimal_number_display_formatter_assert.svh
`ifndef DECIMAL_NUMBER_DISPLAY_FORMATTER_ASSERT_SVH
`define DECIMAL_NUMBER_DISPLAY_FORMATTER_ASSERT_SVH

// Check that holds at every clock edge outside reset.
`define DNDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check with a condition and a consequence in the next cycle.
`define DNDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dndf_pkg.sv
package dndf_pkg;

  localparam int unsigned MagW     = 45;
  localparam int unsigned ExpInW   = 8;
  localparam int unsigned ExpW     = 9;
  localparam int unsigned NumDig   = 13;
  localparam int unsigned BcdDig   = 14;
  localparam int unsigned CharW    = 6;
  localparam int unsigned FixW     = 4;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned MaxChars = 17;

  typedef logic [3:0] bcd_t;

  // one normalized number passed from front to back
  typedef struct packed {
    logic                   neg;
    bcd_t [NumDig-1:0]      digits;
    logic signed [ExpW-1:0] expo;
  } item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [FixW-1:0]  fix;
    logic [ModeW-1:0] mode;
  } cfg_t;

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_NORM, F_PUSH} front_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_CLASS, B_ROUND, B_STRIP, B_FIN, B_EMIT
  } back_state_e;

  typedef enum logic [3:0] {
    PH_SIGN, PH_LDOT, PH_DIG, PH_TDOT, PH_ESGN, PH_E1, PH_E0, PH_SP, PH_Q
  } emit_phase_e;

  // register indexes
  localparam logic CfgFixed = 1'b0;
  localparam logic CfgMode  = 1'b1;

  // modes and fixed-decimal codes
  localparam logic [ModeW-1:0] ModeFloat = 2'd0;
  localparam logic [ModeW-1:0] ModeEng   = 2'd2;
  localparam logic [FixW-1:0]  FixAll    = 4'd9;
  localparam logic [FixW-1:0]  FixMaxExp = 4'd7;

  // character codes (ASCII, low six bits)
  localparam logic [CharW-1:0] ChMinus = 6'd45;
  localparam logic [CharW-1:0] ChDot   = 6'd46;
  localparam logic [CharW-1:0] ChSpace = 6'd32;
  localparam logic [CharW-1:0] ChQuest = 6'd63;
  localparam logic [CharW-1:0] ChZero  = 6'd48;

endpackage

>>> sv/dndf_front.sv
module dndf_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [dndf_pkg::MagW-1:0]      mantissa_i,
  input  logic signed [dndf_pkg::ExpInW-1:0]    exponent_i,
  output logic                                  q_valid_o,
  input  logic                                  q_ready_i,
  output dndf_pkg::item_t                       q_item_o
);

  localparam int unsigned BcdW = 4 * dndf_pkg::BcdDig;

  dndf_pkg::front_state_e state_q, state_d;
  logic [dndf_pkg::MagW-1:0]         bin_q, bin_d;
  logic [BcdW-1:0]                   bcd_q, bcd_d;
  logic [BcdW-1:0]                   adj;
  logic                              neg_q, neg_d;
  logic signed [dndf_pkg::ExpW-1:0]  exp_q, exp_d;
  logic [5:0]                        cnt_q, cnt_d;

  // add-3 correction ahead of each double-dabble shift
  always_comb begin
    for (int k = 0; k < dndf_pkg::BcdDig; k++) begin
      adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? 4'(bcd_q[4*k +: 4] + 4'd3)
                                                : bcd_q[4*k +: 4];
    end
  end

  // accept, convert to BCD, normalize, hand to queue
  always_comb begin
    state_d    = state_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    neg_d      = neg_q;
    exp_d      = exp_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    q_valid_o  = 1'b0;
    unique case (state_q)
      dndf_pkg::F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          neg_d   = mantissa_i[dndf_pkg::MagW-1];
          bin_d   = mantissa_i[dndf_pkg::MagW-1] ? $unsigned(~mantissa_i + 45'sd1)
                                                 : $unsigned(mantissa_i);
          exp_d   = dndf_pkg::ExpW'(exponent_i);
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = dndf_pkg::F_CONV;
        end
      end
      dndf_pkg::F_CONV: begin
        bcd_d = {adj[BcdW-2:0], bin_q[dndf_pkg::MagW-1]};
        bin_d = {bin_q[dndf_pkg::MagW-2:0], 1'b0};
        cnt_d = 6'(cnt_q + 6'd1);
        if (cnt_q == 6'(dndf_pkg::MagW - 1)) state_d = dndf_pkg::F_NORM;
      end
      dndf_pkg::F_NORM: begin
        priority if (bcd_q[BcdW-1 -: 4] != 4'd0) begin
          bcd_d = {4'd0, bcd_q[BcdW-1:4]};
          exp_d = exp_q + 9'sd1;
        end else if (bcd_q != '0 && bcd_q[BcdW-5 -: 4] == 4'd0) begin
          bcd_d = {bcd_q[BcdW-5:0], 4'd0};
          exp_d = exp_q - 9'sd1;
        end else begin
          // zero or underflow becomes a clean zero
          if (bcd_q == '0 || exp_q < -9'sd99) begin
            bcd_d = '0;
            exp_d = '0;
            neg_d = 1'b0;
          end
          state_d = dndf_pkg::F_PUSH;
        end
      end
      dndf_pkg::F_PUSH: begin
        q_valid_o = 1'b1;
        if (q_ready_i) state_d = dndf_pkg::F_IDLE;
      end
      default: state_d = dndf_pkg::F_IDLE;
    endcase
  end

  assign q_item_o.neg    = neg_q;
  assign q_item_o.digits = bcd_q[4*dndf_pkg::NumDig-1:0];
  assign q_item_o.expo   = exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dndf_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
    exp_q <= exp_d;
    cnt_q <= cnt_d;
  end

endmodule

>>> sv/dndf_queue.sv
`include "decimal_number_display_formatter_assert.svh"

module dndf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  dndf_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            pop_i,
  output dndf_pkg::item_t item_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  dndf_pkg::item_t       mem_q [DEPTH];
  logic [AddrW-1:0]      wr_q, rd_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AddrW'(DEPTH - 1)) ? '0 : AddrW'(wr_q + 1'b1);
      if (do_pop)  rd_q <= (rd_q == AddrW'(DEPTH - 1)) ? '0 : AddrW'(rd_q + 1'b1);
      if (do_push && !do_pop)      cnt_q <= CntW'(cnt_q + 1'b1);
      else if (do_pop && !do_push) cnt_q <= CntW'(cnt_q - 1'b1);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

  `DNDF_ASSERT(a_cnt_bound, cnt_q <= CntW'(DEPTH), "queue count above depth")
  `DNDF_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, cnt_q == CntW'($past(cnt_q) - 1'b1), "pop lost")
  `DNDF_ASSERT_NEXT(a_push_grows, do_push && !do_pop, cnt_q == CntW'($past(cnt_q) + 1'b1), "push lost")

endmodule

>>> sv/dndf_back.sv
module dndf_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  output logic                           q_ready_o,
  input  dndf_pkg::item_t                q_item_i,
  input  dndf_pkg::cfg_t                 cfg_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dndf_pkg::CharW-1:0]     char_code_o,
  output logic                           last_char_o
);

  localparam int unsigned ND = dndf_pkg::NumDig;
  localparam int unsigned MD = dndf_pkg::BcdDig;

  dndf_pkg::back_state_e state_q, state_d;
  dndf_pkg::emit_phase_e phase_q, phase_d;
  logic                             neg_q, neg_d;
  dndf_pkg::bcd_t [ND-1:0]          dig_q, dig_d;
  logic signed [dndf_pkg::ExpW-1:0] exp_q, exp_d;
  logic                             is_exp_q, is_exp_d;
  logic                             err_q, err_d;
  logic [4:0]                       ilen_q, ilen_d;
  logic [4:0]                       frac_q, frac_d;
  logic [4:0]                       mlen_q, mlen_d;
  logic signed [5:0]                keep_q, keep_d;
  logic signed [dndf_pkg::ExpW-1:0] de_q, de_d;
  dndf_pkg::bcd_t [MD-1:0]          mant_q, mant_d;
  logic [4:0]                       j_q, j_d, tot_q, tot_d, cnt_q, cnt_d;
  logic                             ov_q, ov_d, last_q, last_d;
  logic [dndf_pkg::CharW-1:0]       ch_q, ch_d;

  logic [3:0] fix;
  logic [2:0] fix7;
  assign fix  = cfg_i.fix;
  assign fix7 = (fix < dndf_pkg::FixMaxExp) ? fix[2:0] : 3'(dndf_pkg::FixMaxExp);

  // classification of the current number
  logic c_zero, c_ovf, c_big, c_small, c_all9, c_exp, c_eng, c_tozero;
  logic [7:0] c_x, c_q3;
  logic [16:0] c_prod;
  logic [1:0] c_r;
  logic [4:0] c_ilen, c_mlen0, c_frac0, c_frac, c_mlen;
  logic signed [5:0] c_keep;
  logic signed [dndf_pkg::ExpW-1:0] c_de;
  dndf_pkg::bcd_t [MD-1:0] c_nines;

  always_comb begin
    c_zero   = (dig_q[ND-1] == 4'd0);
    c_ovf    = !c_zero && (exp_q >= 9'sd100);
    c_big    = exp_q >= 9'sd10;
    c_small  = (exp_q <= -9'sd12) || (exp_q == -9'sd11 && dig_q[ND-1] < 4'd5);
    c_all9   = (fix == dndf_pkg::FixAll);
    c_eng    = (cfg_i.mode == dndf_pkg::ModeEng);
    c_exp    = (cfg_i.mode != dndf_pkg::ModeFloat) || c_big || (c_small && c_all9);
    c_tozero = c_small && !c_all9 && (cfg_i.mode == dndf_pkg::ModeFloat);
    // (e + 99) mod 3 through a reciprocal multiply
    c_x    = 8'(exp_q + 9'sd99);
    c_prod = 17'(c_x) * 17'd171;
    c_q3   = c_prod[16:9];
    c_r    = 2'(c_x - 8'(c_q3 * 8'd3));
    if (c_exp) c_ilen = c_eng ? 5'(5'd1 + 5'(c_r)) : 5'd1;
    else       c_ilen = (exp_q >= 9'sd0) ? 5'(exp_q + 9'sd1) : 5'd0;
    c_de    = (c_exp && c_eng) ? exp_q - $signed({7'd0, c_r}) : exp_q;
    c_mlen0 = c_exp ? 5'd8 : 5'd10;
    c_frac0 = 5'(c_mlen0 - c_ilen);
    if (!c_all9) begin
      c_frac = (c_frac0 > 5'(fix)) ? 5'(fix) : c_frac0;
      c_mlen = 5'(c_ilen + c_frac);
    end else begin
      c_frac = c_frac0;
      c_mlen = c_mlen0;
    end
    if (!c_exp && exp_q < 9'sd0) c_keep = $signed({1'b0, c_frac}) + 6'(exp_q) + 6'sd1;
    else                         c_keep = $signed({1'b0, c_mlen});
    for (int k = 0; k < MD; k++) begin
      c_nines[k] = (k <= int'(fix7)) ? 4'd9 : 4'd0;
    end
  end

  // rounding: take kept digits, round half up
  logic r_kneg, r_rnd, r_all9, r_renorm;
  logic [3:0] r_ku;
  logic [4:0] r_src;
  dndf_pkg::bcd_t [MD-1:0] r_m, r_mi;
  dndf_pkg::bcd_t r_rd;
  logic [MD-1:0] r_nine, r_kmask, r_low;

  always_comb begin
    r_kneg = keep_q[5];
    r_ku   = keep_q[3:0];
    r_src  = '0;
    for (int k = 0; k < MD; k++) begin
      r_src = 5'(5'(k) + 5'd13 - 5'(r_ku));
      if (!r_kneg && 4'(k) < r_ku) r_m[k] = dig_q[r_src[3:0]];
      else                         r_m[k] = 4'd0;
      r_nine[k] = (r_m[k] == 4'd9);
    end
    for (int k = 0; k < MD; k++) begin
      r_low = 14'((15'd1 << k) - 15'd1);
      if ((r_nine & r_low) == r_low) r_mi[k] = r_nine[k] ? 4'd0 : 4'(r_m[k] + 4'd1);
      else                           r_mi[k] = r_m[k];
    end
    r_rd     = r_kneg ? 4'd0 : dig_q[4'(4'd12 - r_ku)];
    r_rnd    = !r_kneg && (r_rd >= 4'd5);
    r_kmask  = 14'((15'd1 << r_ku) - 15'd1);
    r_all9   = (r_nine & r_kmask) == r_kmask;
    r_renorm = r_rnd && r_all9 && (keep_q == $signed({1'b0, mlen_q}));
  end

  // final layout fix-ups
  logic [4:0] f_ilen, f_frac;
  logic f_neg;
  logic signed [dndf_pkg::ExpW-1:0] f_de;

  always_comb begin
    f_ilen = ilen_q;
    f_frac = frac_q;
    f_neg  = neg_q;
    f_de   = de_q;
    if (ilen_q == 5'd0 && mlen_q < 5'd10) f_ilen = 5'd1;
    if (mant_q == '0) begin
      f_neg  = 1'b0;
      f_ilen = 5'd1;
      f_frac = (fix < dndf_pkg::FixAll) ? (is_exp_q ? 5'(fix7) : 5'(fix)) : 5'd0;
      f_de   = '0;
    end
  end

  // character generator
  logic [6:0] e_abs;
  logic [14:0] e_prod;
  logic [3:0] e_tens, e_ones;
  logic [4:0] e_sh;
  logic e_jlast, e_done, t_done;
  dndf_pkg::emit_phase_e e_phase, t_phase;
  logic [4:0] e_j;
  logic [dndf_pkg::CharW-1:0] e_ch;

  always_comb begin
    e_abs   = (de_q < 0) ? 7'(-de_q) : 7'(de_q);
    e_prod  = 15'(e_abs) * 15'd205;
    e_tens  = e_prod[14:11];
    e_ones  = 4'(e_abs - 7'(e_tens * 7'd10));
    e_sh    = 5'(tot_q - 5'd1 - j_q);
    e_jlast = (j_q == 5'(tot_q - 5'd1));
    // what follows the digits
    t_done  = 1'b0;
    if (is_exp_q)   t_phase = dndf_pkg::PH_ESGN;
    else if (err_q) t_phase = dndf_pkg::PH_SP;
    else begin
      t_phase = dndf_pkg::PH_Q;
      t_done  = 1'b1;
    end
    e_ch    = dndf_pkg::ChSpace;
    e_done  = 1'b0;
    e_phase = phase_q;
    e_j     = j_q;
    unique case (phase_q)
      dndf_pkg::PH_SIGN: begin
        e_ch    = dndf_pkg::ChMinus;
        e_phase = (ilen_q == 5'd0) ? dndf_pkg::PH_LDOT : dndf_pkg::PH_DIG;
      end
      dndf_pkg::PH_LDOT: begin
        e_ch    = dndf_pkg::ChDot;
        e_phase = dndf_pkg::PH_DIG;
      end
      dndf_pkg::PH_DIG: begin
        e_ch = 6'(dndf_pkg::ChZero + 6'(mant_q[e_sh[3:0]]));
        priority if (5'(j_q + 5'd1) == ilen_q) begin
          e_phase = dndf_pkg::PH_TDOT;
        end else if (e_jlast) begin
          e_phase = t_phase;
          e_done  = t_done;
        end else begin
          e_j = 5'(j_q + 5'd1);
        end
      end
      dndf_pkg::PH_TDOT: begin
        e_ch = dndf_pkg::ChDot;
        if (e_jlast) begin
          e_phase = t_phase;
          e_done  = t_done;
        end else begin
          e_j     = 5'(j_q + 5'd1);
          e_phase = dndf_pkg::PH_DIG;
        end
      end
      dndf_pkg::PH_ESGN: begin
        e_ch    = (de_q < 0) ? dndf_pkg::ChMinus : dndf_pkg::ChSpace;
        e_phase = dndf_pkg::PH_E1;
      end
      dndf_pkg::PH_E1: begin
        e_ch    = 6'(dndf_pkg::ChZero + 6'(e_tens));
        e_phase = dndf_pkg::PH_E0;
      end
      dndf_pkg::PH_E0: begin
        e_ch = 6'(dndf_pkg::ChZero + 6'(e_ones));
        if (err_q) e_phase = dndf_pkg::PH_SP;
        else       e_done  = 1'b1;
      end
      dndf_pkg::PH_SP: begin
        e_ch    = dndf_pkg::ChSpace;
        e_phase = dndf_pkg::PH_Q;
      end
      dndf_pkg::PH_Q: begin
        e_ch   = dndf_pkg::ChQuest;
        e_done = 1'b1;
      end
      default: e_done = 1'b1;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    neg_d     = neg_q;
    dig_d     = dig_q;
    exp_d     = exp_q;
    is_exp_d  = is_exp_q;
    err_d     = err_q;
    ilen_d    = ilen_q;
    frac_d    = frac_q;
    mlen_d    = mlen_q;
    keep_d    = keep_q;
    de_d      = de_q;
    mant_d    = mant_q;
    j_d       = j_q;
    tot_d     = tot_q;
    cnt_d     = cnt_q;
    ch_d      = ch_q;
    last_d    = last_q;
    ov_d      = ov_q && !out_ready_i;
    q_ready_o = 1'b0;
    unique case (state_q)
      dndf_pkg::B_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          neg_d   = q_item_i.neg;
          dig_d   = q_item_i.digits;
          exp_d   = q_item_i.expo;
          state_d = dndf_pkg::B_CLASS;
        end
      end
      dndf_pkg::B_CLASS: begin
        priority if (c_ovf) begin
          // overflow: nines, exponent 99, error mark
          mant_d   = c_nines;
          ilen_d   = 5'd1;
          mlen_d   = 5'(5'd1 + 5'(fix7));
          frac_d   = 5'(fix7);
          is_exp_d = 1'b1;
          err_d    = 1'b1;
          de_d     = 9'sd99;
          state_d  = dndf_pkg::B_FIN;
        end else if (c_tozero) begin
          dig_d = '0;
          exp_d = '0;
          neg_d = 1'b0;
        end else begin
          is_exp_d = c_exp;
          err_d    = 1'b0;
          ilen_d   = c_ilen;
          frac_d   = c_frac;
          mlen_d   = c_mlen;
          keep_d   = c_keep;
          de_d     = c_de;
          state_d  = dndf_pkg::B_ROUND;
        end
      end
      dndf_pkg::B_ROUND: begin
        if (r_renorm) begin
          // carry out of the top digit: restart as 1.0 at next exponent
          dig_d        = '0;
          dig_d[ND-1]  = 4'd1;
          exp_d        = exp_q + 9'sd1;
          state_d      = dndf_pkg::B_CLASS;
        end else begin
          mant_d  = r_rnd ? r_mi : r_m;
          state_d = dndf_pkg::B_STRIP;
        end
      end
      dndf_pkg::B_STRIP: begin
        // in all-digits mode, drop trailing zeros one digit a cycle
        if (fix == dndf_pkg::FixAll && mant_q != '0 && mant_q[0] == 4'd0 &&
            frac_q != 5'd0) begin
          mant_d = mant_q >> 4;
          frac_d = 5'(frac_q - 5'd1);
          mlen_d = 5'(mlen_q - 5'd1);
        end else begin
          state_d = dndf_pkg::B_FIN;
        end
      end
      dndf_pkg::B_FIN: begin
        neg_d   = f_neg;
        ilen_d  = f_ilen;
        frac_d  = f_frac;
        de_d    = f_de;
        tot_d   = 5'(f_ilen + f_frac);
        j_d     = '0;
        cnt_d   = '0;
        if (f_neg)                phase_d = dndf_pkg::PH_SIGN;
        else if (f_ilen == 5'd0)  phase_d = dndf_pkg::PH_LDOT;
        else                      phase_d = dndf_pkg::PH_DIG;
        state_d = dndf_pkg::B_EMIT;
      end
      dndf_pkg::B_EMIT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ch_d    = e_ch;
          phase_d = e_phase;
          j_d     = e_j;
          cnt_d   = 5'(cnt_q + 5'd1);
          last_d  = e_done || (cnt_q == 5'(dndf_pkg::MaxChars - 1));
          if (last_d) state_d = dndf_pkg::B_IDLE;
        end
      end
      default: state_d = dndf_pkg::B_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign char_code_o = ch_q;
  assign last_char_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dndf_pkg::B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q  <= phase_d;
    neg_q    <= neg_d;
    dig_q    <= dig_d;
    exp_q    <= exp_d;
    is_exp_q <= is_exp_d;
    err_q    <= err_d;
    ilen_q   <= ilen_d;
    frac_q   <= frac_d;
    mlen_q   <= mlen_d;
    keep_q   <= keep_d;
    de_q     <= de_d;
    mant_q   <= mant_d;
    j_q      <= j_d;
    tot_q    <= tot_d;
    cnt_q    <= cnt_d;
    ch_q     <= ch_d;
    last_q   <= last_d;
  end

endmodule

>>> sv/decimal_number_display_formatter.sv
// Channel  Dir  Handshake                Payload
// cfg      in   cfg_we_i                 cfg_index_i, cfg_data_i
// in       in   in_valid_i / in_ready_o  mantissa_i, exponent_i
// out      out  out_valid_o/out_ready_i  char_code_o, last_char_o
//
// Front: accept, double-dabble BCD conversion, normalize, then one queue
//   push per word.
// Back: pop, classify, round, strip trailing zeros one digit a cycle in
//   all-digits mode (a rounding carry repeats classify and round), then
//   one character per cycle unless stalled, at most 17; front runs ahead.
// The BCD converter in the front sets the sustained rate.
// Reset (rst_ni low) empties the queue, drops any pending output and
//   restores fixed_decimals to 9 and display_mode to float.
// A stall on out_ready_i holds the back; the front keeps filling the queue.
module decimal_number_display_formatter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [dndf_pkg::FixW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [dndf_pkg::MagW-1:0]   mantissa_i,
  input  logic signed [dndf_pkg::ExpInW-1:0] exponent_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dndf_pkg::CharW-1:0]         char_code_o,
  output logic                               last_char_o
);

  logic [dndf_pkg::FixW-1:0]  fix_q;
  logic [dndf_pkg::ModeW-1:0] mode_q;
  dndf_pkg::cfg_t             cfg;
  logic                       push, q_rdy, q_vld, pop;
  dndf_pkg::item_t            push_item, pop_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_q  <= dndf_pkg::FixAll;
      mode_q <= dndf_pkg::ModeFloat;
    end else if (cfg_we_i) begin
      if (cfg_index_i == dndf_pkg::CfgFixed) fix_q <= cfg_data_i;
      else                                   mode_q <= cfg_data_i[dndf_pkg::ModeW-1:0];
    end
  end

  // values above 9 act as "all digits"
  assign cfg.fix  = (fix_q > dndf_pkg::FixAll) ? dndf_pkg::FixAll : fix_q;
  assign cfg.mode = mode_q;

  dndf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mantissa_i (mantissa_i),
    .exponent_i (exponent_i),
    .q_valid_o  (push),
    .q_ready_i  (q_rdy),
    .q_item_o   (push_item)
  );

  dndf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_rdy),
    .item_i  (push_item),
    .valid_o (q_vld),
    .pop_i   (pop),
    .item_o  (pop_item)
  );

  dndf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_vld),
    .q_ready_o   (pop),
    .q_item_i    (pop_item),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule

>>> bench/tb_decimal_number_display_formatter.sv
`timescale 1ns / 100ps

module tb_decimal_number_display_formatter;

  typedef struct packed {
    logic [dndf_pkg::CharW-1:0] code;
    logic                       last;
  } disp_char_t;

  localparam longint unsigned Pow10 [14] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
    64'd100000000000, 64'd1000000000000, 64'd10000000000000
  };
  localparam int unsigned IdleLimit = 3000;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic                               cfg_index_i = dndf_pkg::CfgFixed;
  logic [dndf_pkg::FixW-1:0]          cfg_data_i = '0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic signed [dndf_pkg::MagW-1:0]   mantissa_i = '0;
  logic signed [dndf_pkg::ExpInW-1:0] exponent_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic [dndf_pkg::CharW-1:0]         char_code_o;
  logic                               last_char_o;

  // shadow of the block's registers
  logic [dndf_pkg::FixW-1:0]  fix_shadow = dndf_pkg::FixAll;
  logic [dndf_pkg::ModeW-1:0] mode_shadow = dndf_pkg::ModeFloat;

  disp_char_t  pending_chars[$];
  int unsigned error_count = 0;
  int unsigned hold_len = 0;
  bit          send_idle = 1'b1;
  bit          sink_idle = 1'b1;
  int unsigned quiet_cycles = 0;

  decimal_number_display_formatter DUT (.*);

  always #5 clk_i = ~clk_i;

  // text builder with the 17-character cap
  function automatic void put_char(ref disp_char_t txt[$],
                                   input logic [dndf_pkg::CharW-1:0] c);
    if (txt.size() < dndf_pkg::MaxChars) txt.push_back('{code: c, last: 1'b0});
  endfunction

  function automatic void build_text(ref disp_char_t txt[$], input bit neg,
                                     input longint unsigned mant, input int int_len,
                                     input int fpart_len, input bit show_exp,
                                     input int ex, input bit err);
    int total;
    int sh;
    int a;
    total = int_len + fpart_len;
    if (neg) put_char(txt, dndf_pkg::ChMinus);
    for (int j = 0; j < total; j++) begin
      sh = total - 1 - j;
      if (j == 0 && int_len == 0) put_char(txt, dndf_pkg::ChDot);
      if (sh >= 0 && sh <= 13) begin
        put_char(txt, dndf_pkg::ChZero + dndf_pkg::CharW'((mant / Pow10[sh]) % 10));
      end
      if (j + 1 == int_len) put_char(txt, dndf_pkg::ChDot);
    end
    if (show_exp) begin
      a = ex < 0 ? -ex : ex;
      put_char(txt, ex < 0 ? dndf_pkg::ChMinus : dndf_pkg::ChSpace);
      put_char(txt, dndf_pkg::ChZero + dndf_pkg::CharW'((a / 10) % 10));
      put_char(txt, dndf_pkg::ChZero + dndf_pkg::CharW'(a % 10));
    end
    if (err) begin
      put_char(txt, dndf_pkg::ChSpace);
      put_char(txt, dndf_pkg::ChQuest);
    end
    if (txt.size() > 0) txt[txt.size()-1].last = 1'b1;
  endfunction

  // expected display text of one number under the current settings
  function automatic void format_number(input logic [dndf_pkg::MagW-1:0] raw,
                                        input logic [dndf_pkg::ExpInW-1:0] eraw);
    disp_char_t      txt[$];
    bit              neg, is_big, tiny, is_exp, rnd;
    longint unsigned mag, mant;
    int              e, fix, f, mlen, int_len, frac, keep, de, ne;
    neg = raw[dndf_pkg::MagW-1];
    mag = neg ? longint'(-raw) & ((64'd1 << dndf_pkg::MagW) - 1) : longint'(raw);
    e   = int'($signed(eraw));
    fix = fix_shadow > dndf_pkg::FixAll ? 9 : int'(fix_shadow);
    if (mag >= Pow10[13]) begin
      mag = mag / 10;
      e++;
    end
    if (mag != 0) begin
      while (mag < Pow10[12]) begin
        mag = mag * 10;
        e--;
      end
    end
    if (mag == 0 || e < -99) begin
      mag = 0; e = 0; neg = 0;
    end
    forever begin
      if (mag != 0 && e >= 100) begin
        f = fix < 7 ? fix : 7;
        build_text(txt, neg, Pow10[1+f] - 1, 1, f, 1'b1, 99, 1'b1);
        break;
      end
      is_big = e >= 10;
      tiny   = e <= -12 || (e == -11 && mag < 5 * Pow10[12]);
      is_exp = mode_shadow != dndf_pkg::ModeFloat || is_big || (tiny && fix == 9);
      // too small for the fixed decimals: shown as zero
      if (tiny && fix != 9 && mode_shadow == dndf_pkg::ModeFloat) begin
        mag = 0; e = 0; neg = 0;
        continue;
      end
      mlen = is_exp ? 8 : 10;
      de = e;
      if (is_exp) begin
        int_len = 1;
        if (mode_shadow == dndf_pkg::ModeEng) begin
          ne = ((e + 99) / 3) * 3 - 99;
          int_len = 1 + e - ne;
          de = ne;
        end
      end else begin
        int_len = e + 1 > 0 ? e + 1 : 0;
      end
      frac = mlen - int_len;
      if (fix != 9) begin
        if (frac > fix) frac = fix;
        mlen = int_len + frac;
      end
      keep = mlen;
      if (!is_exp && e < 0) keep = frac + e + 1;
      if (keep < 0 || keep > 10) begin
        mant = 0; rnd = 0;
      end else begin
        mant = mag / Pow10[13-keep];
        rnd  = (mag / Pow10[12-keep]) % 10 >= 5;
      end
      // rounding carry out of the top digit: renormalize and retry
      if (rnd) begin
        mant++;
        if (mlen >= 0 && mlen <= 13 && mant >= Pow10[mlen]) begin
          mag = Pow10[12];
          e++;
          continue;
        end
      end
      if (mant != 0 && fix == 9) begin
        while (mant % 10 == 0 && frac > 0) begin
          mant = mant / 10; frac--; mlen--;
        end
      end
      if (int_len == 0 && mlen < 10) begin
        int_len++; mlen++;
      end
      if (mant == 0) begin
        neg = 0;
        int_len = 1;
        frac = 0;
        if (fix < 9) frac = is_exp ? (fix < 7 ? fix : 7) : fix;
        de = 0;
      end
      build_text(txt, neg, mant, int_len, frac, is_exp, de, 1'b0);
      break;
    end
    foreach (txt[i]) pending_chars.push_back(txt[i]);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  // offer one word and wait for it to be taken; valid stays up for the next word
  task automatic send_word(input logic signed [dndf_pkg::MagW-1:0] m,
                           input logic signed [dndf_pkg::ExpInW-1:0] ex);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mantissa_i <= m;
    exponent_i <= ex;
    do @(posedge clk_i); while (!in_ready_o);
    format_number(m, ex);
  endtask

  // registers change only with the block drained
  task automatic set_config(input logic [dndf_pkg::FixW-1:0] fix,
                            input logic [dndf_pkg::FixW-1:0] mode);
    in_valid_i <= 1'b0;
    wait (pending_chars.size() == 0);
    repeat (80) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= dndf_pkg::CfgFixed;
    cfg_data_i  <= fix;
    @(posedge clk_i);
    cfg_index_i <= dndf_pkg::CfgMode;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    fix_shadow  = fix;
    mode_shadow = mode[dndf_pkg::ModeW-1:0];
  endtask

  function automatic logic signed [dndf_pkg::MagW-1:0] rand_mag();
    longint unsigned v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: v = Pow10[13] - 1 - (v % 1000);                 // runs of nines
      1: v = Pow10[12] * $urandom_range(1, 9) + (v % 100); // trailing zeros
      default: v = Pow10[12] + v % (9 * Pow10[12]);
    endcase
    return dndf_pkg::MagW'(v);
  endfunction

  task automatic send_random(input int unsigned n);
    logic signed [dndf_pkg::MagW-1:0]   m;
    logic signed [dndf_pkg::ExpInW-1:0] ex;
    for (int unsigned k = 0; k < n; k++) begin
      m  = rand_mag();
      ex = dndf_pkg::ExpInW'($urandom_range(0, 30) - 15);
      case ($urandom_range(0, 9))
        0: m = dndf_pkg::MagW'({$urandom, $urandom});
        1: ex = dndf_pkg::ExpInW'($urandom);
        2: m = dndf_pkg::MagW'($urandom_range(0, 99999));
        default: ;
      endcase
      if ($urandom_range(0, 1)) m = -m;
      send_word(m, ex);
    end
  endtask

  task automatic test_directed();
    send_word('0, '0);
    send_word(dndf_pkg::MagW'(Pow10[12]), 8'sd0);
    send_word(-dndf_pkg::MagW'(Pow10[13] - 1), 8'sd99);
    send_word(dndf_pkg::MagW'(Pow10[13] - 1), 8'sd0);
    send_word(dndf_pkg::MagW'(Pow10[12]), -8'sd99);
    send_word(dndf_pkg::MagW'(Pow10[12]), -8'sd12);
    send_word(dndf_pkg::MagW'(5 * Pow10[12]), -8'sd11);
    send_word(-dndf_pkg::MagW'(5 * Pow10[12] - 1), -8'sd11);
    send_word(dndf_pkg::MagW'(64'd1234567890123), 8'sd9);
    send_word(dndf_pkg::MagW'(64'd1234567890123), 8'sd10);
    send_word(dndf_pkg::MagW'(1), 8'sd5);
    send_word({1'b1, {(dndf_pkg::MagW-1){1'b0}}}, 8'sd127);
    send_word(dndf_pkg::MagW'(Pow10[12]), 8'sh80);
    set_config(4'd0, 4'd0);
    send_word(dndf_pkg::MagW'(5 * Pow10[12]), -8'sd1);
    send_word(dndf_pkg::MagW'(9 * Pow10[12]), -8'sd2);
    send_word(-dndf_pkg::MagW'(64'd9999999999999), 8'sd9);
    set_config(4'd2, 4'd0);
    send_word(dndf_pkg::MagW'(Pow10[12]), -8'sd20);
    set_config(4'd8, 4'd1);
    send_word(-dndf_pkg::MagW'(Pow10[13] - 1), 8'sd99);
    send_word('0, '0);
    set_config(4'd3, 4'd2);
    send_word(dndf_pkg::MagW'(64'd4567891234567), -8'sd7);
    send_word(dndf_pkg::MagW'(Pow10[13] - 1), 8'sd98);
    set_config(4'd15, 4'd3);
    send_word(-dndf_pkg::MagW'(64'd1234567890123), -8'sd50);
  endtask

  task automatic test_random_settings();
    logic [dndf_pkg::FixW-1:0] fixes[8] = '{4'd9, 4'd0, 4'd8, 4'd3, 4'd9, 4'd15, 4'd5, 4'd0};
    logic [dndf_pkg::FixW-1:0] modes[8] = '{4'd0, 4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd0, 4'd2};
    for (int i = 0; i < 8; i++) begin
      set_config(fixes[i], modes[i]);
      send_idle = (i % 3) != 2;
      sink_idle = (i % 4) != 3;
      send_random(18);
    end
    send_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // receiver stops for a long while; sender keeps pushing back to back
  task automatic test_backpressure();
    set_config(4'd9, 4'd1);
    send_idle = 1'b0;
    hold_len  = 500;
    send_random(10);
    send_idle = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_settings();
    test_backpressure();
    in_valid_i <= 1'b0;
    wait (pending_chars.size() == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("decimal_number_display_formatter: match");
    end else begin
      $display("decimal_number_display_formatter: mismatch");
    end
    $finish;
  end

  // output side: random stalls, long hold when asked
  initial begin
    int unsigned stall;
    disp_char_t  exp_c;
    @(posedge rst_ni);
    forever begin
      stall = sink_idle ? $urandom_range(0, 4) : 0;
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char %0d", char_code_o));
      end else begin
        exp_c = pending_chars.pop_front();
        if (char_code_o !== exp_c.code)
          flag_mismatch($sformatf("char %0d, want %0d", char_code_o, exp_c.code));
        if (last_char_o !== exp_c.last)
          flag_mismatch($sformatf("last flag %0b, want %0b", last_char_o, exp_c.last));
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("decimal_number_display_formatter: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
